### src/mbet_pkg.sv
// ----------------------------------------------------------------------------
// mbet_pkg
// Types, constants and helpers shared by the escape-time pixel evaluator.
// ----------------------------------------------------------------------------
package mbet_pkg;

  localparam int MBET_MAX_ITER  = 30;
  localparam int MBET_FRAC_BITS = 28;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_ORIGIN_REAL = 2'd0;
  localparam logic [1:0] REG_ORIGIN_IMAG = 2'd1;
  localparam logic [1:0] REG_PIXEL_STEP  = 2'd2;

  localparam logic [31:0] ORIGIN_REAL_RST = 32'hE000_0000;
  localparam logic [31:0] ORIGIN_IMAG_RST = 32'hE000_0000;
  localparam logic [27:0] PIXEL_STEP_RST  = 28'd2147484;

  typedef struct packed {
    logic [9:0] pixel_column;
    logic [9:0] pixel_row;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] gray_level;
    logic [7:0] iteration_count;
    logic       escaped;
  } pix_out_t;

  typedef struct packed {
    logic [31:0] origin_real;
    logic [31:0] origin_imag;
    logic [27:0] pixel_step;
  } cfg_t;

  // Operand pairs for the three multiplier lanes, two's complement
  typedef struct packed {
    logic [31:0] a0;
    logic [31:0] b0;
    logic [31:0] a1;
    logic [31:0] b1;
    logic [31:0] a2;
    logic [31:0] b2;
  } mul_ops_t;

  typedef struct packed {
    logic [63:0] p0;
    logic [63:0] p1;
    logic [63:0] p2;
  } mul_prods_t;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_SETUP_MUL = 6'b000010,
    S_SETUP_ADD = 6'b000100,
    S_ITER_MUL  = 6'b001000,
    S_ITER_EVAL = 6'b010000,
    S_FINISH    = 6'b100000
  } mbet_state_t;

  // Clamp a wide signed value to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

### src/mbet_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbet_cfg_regs
// Viewport registers: origin of the pixel grid and step per pixel.
// ----------------------------------------------------------------------------
module mbet_cfg_regs
  import mbet_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  logic [31:0] origin_real_r;
  logic [31:0] origin_imag_r;
  logic [27:0] pixel_step_r;

  assign cfg_ready = 1'b1;

  // Indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_real_r <= ORIGIN_REAL_RST;
      origin_imag_r <= ORIGIN_IMAG_RST;
      pixel_step_r  <= PIXEL_STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_REAL: origin_real_r <= cfg_data;
        REG_ORIGIN_IMAG: origin_imag_r <= cfg_data;
        REG_PIXEL_STEP:  pixel_step_r  <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  assign cfg.origin_real = origin_real_r;
  assign cfg.origin_imag = origin_imag_r;
  assign cfg.pixel_step  = pixel_step_r;

endmodule

### src/mbet_mul_unit.sv
// ----------------------------------------------------------------------------
// mbet_mul_unit
// Shared three-lane signed 32x32 multiplier with registered products.
// ----------------------------------------------------------------------------
module mbet_mul_unit
  import mbet_pkg::*;
(
  input  logic       clk,
  input  mul_ops_t   ops,
  output mul_prods_t prods
);

  logic [63:0] p0_r;
  logic [63:0] p1_r;
  logic [63:0] p2_r;

  always_ff @(posedge clk) begin
    p0_r <= 64'($signed(ops.a0) * $signed(ops.b0));
    p1_r <= 64'($signed(ops.a1) * $signed(ops.b1));
    p2_r <= 64'($signed(ops.a2) * $signed(ops.b2));
  end

  assign prods.p0 = p0_r;
  assign prods.p1 = p1_r;
  assign prods.p2 = p2_r;

endmodule

### src/mbet_iter_core.sv
// ----------------------------------------------------------------------------
// mbet_iter_core
// Sequencer: maps the pixel to c, then runs z = z*z + c rounds through the
// shared multiplier, a multiply state and an evaluate state per round.
// ----------------------------------------------------------------------------
module mbet_iter_core
  import mbet_pkg::*;
#(
  parameter int MAX_ITERATIONS = MBET_MAX_ITER,
  parameter int FRACTION_BITS  = MBET_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       start,
  output logic       idle,
  input  pix_in_t    pix,
  output mul_ops_t   ops,
  input  mul_prods_t prods,
  output logic       res_valid,
  input  logic       res_take,
  output pix_out_t   result
);

  localparam logic [7:0]         MAX_K = 8'(MAX_ITERATIONS);
  localparam logic [7:0]         Q255  = 8'(255 / MAX_ITERATIONS);
  localparam logic [8:0]         R255  = 9'(255 % MAX_ITERATIONS);
  localparam logic [8:0]         MAX9  = 9'(MAX_ITERATIONS);
  localparam logic signed [63:0] FOUR  = 64'sd4 <<< FRACTION_BITS;

  mbet_state_t state_r, state_nxt;
  logic [9:0]  col_r;
  logic [9:0]  row_r;
  logic [31:0] cr_r, cr_nxt;
  logic [31:0] ci_r, ci_nxt;
  logic [31:0] zr_r, zr_nxt;
  logic [31:0] zi_r, zi_nxt;
  logic [7:0]  iter_r, iter_nxt;
  logic [7:0]  quo_r, quo_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic        esc_r, esc_nxt;

  logic signed [63:0] rr, ii, ri, mag;
  logic signed [63:0] cr_ext, ci_ext;
  logic [8:0]         rem_sum;
  logic [8:0]         up;
  logic               escape_now;

  always_ff @(posedge clk) begin
    if (start) begin
      col_r <= pix.pixel_column;
      row_r <= pix.pixel_row;
    end
  end

  // Multiplier lanes: column, row times step at setup; squares, zr*zi after
  always_comb begin
    if (state_r == S_SETUP_MUL) begin
      ops.a0 = {22'd0, col_r};
      ops.b0 = {4'd0, cfg.pixel_step};
      ops.a1 = {22'd0, row_r};
      ops.b1 = {4'd0, cfg.pixel_step};
      ops.a2 = 32'd0;
      ops.b2 = 32'd0;
    end else begin
      ops.a0 = zr_r;
      ops.b0 = zr_r;
      ops.a1 = zi_r;
      ops.b1 = zi_r;
      ops.a2 = zr_r;
      ops.b2 = zi_r;
    end
  end

  assign rr         = $signed(prods.p0) >>> FRACTION_BITS;
  assign ii         = $signed(prods.p1) >>> FRACTION_BITS;
  assign ri         = $signed(prods.p2) >>> (FRACTION_BITS - 1);
  assign mag        = rr + ii;
  assign escape_now = (mag >= FOUR);
  assign cr_ext     = {{32{cr_r[31]}}, cr_r};
  assign ci_ext     = {{32{ci_r[31]}}, ci_r};
  assign rem_sum    = {1'b0, rem_r} + R255;

  always_comb begin
    state_nxt = state_r;
    cr_nxt    = cr_r;
    ci_nxt    = ci_r;
    zr_nxt    = zr_r;
    zi_nxt    = zi_r;
    iter_nxt  = iter_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    esc_nxt   = esc_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SETUP_MUL;
      end
      S_SETUP_MUL: begin
        state_nxt = S_SETUP_ADD;
      end
      S_SETUP_ADD: begin
        cr_nxt    = sat32($signed({{32{cfg.origin_real[31]}}, cfg.origin_real})
                          + $signed(prods.p0));
        ci_nxt    = sat32($signed({{32{cfg.origin_imag[31]}}, cfg.origin_imag})
                          + $signed(prods.p1));
        zr_nxt    = cr_nxt;
        zi_nxt    = ci_nxt;
        iter_nxt  = 8'd0;
        quo_nxt   = 8'd0;
        rem_nxt   = 8'd0;
        esc_nxt   = 1'b0;
        state_nxt = S_ITER_MUL;
      end
      S_ITER_MUL: begin
        state_nxt = S_ITER_EVAL;
      end
      S_ITER_EVAL: begin
        if (escape_now) begin
          esc_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else begin
          zr_nxt   = sat32(rr - ii + cr_ext);
          zi_nxt   = sat32(ri + ci_ext);
          iter_nxt = iter_r + 8'd1;
          // track floor(255*k/MAX) and its remainder as k advances
          if (rem_sum >= MAX9) begin
            rem_nxt = 8'(rem_sum - MAX9);
            quo_nxt = quo_r + Q255 + 8'd1;
          end else begin
            rem_nxt = rem_sum[7:0];
            quo_nxt = quo_r + Q255;
          end
          state_nxt = (iter_nxt == MAX_K) ? S_FINISH : S_ITER_MUL;
        end
      end
      S_FINISH: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cr_r   <= cr_nxt;
    ci_r   <= ci_nxt;
    zr_r   <= zr_nxt;
    zi_r   <= zi_nxt;
    iter_r <= iter_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    esc_r  <= esc_nxt;
  end

  // ceiling of 255*k/MAX
  assign up = {1'b0, quo_r} + {8'd0, (rem_r != 8'd0)};

  assign idle                   = (state_r == S_IDLE);
  assign res_valid              = (state_r == S_FINISH);
  assign result.gray_level      = esc_r ? 8'(9'd255 - up) : 8'd0;
  assign result.iteration_count = esc_r ? iter_r : MAX_K;
  assign result.escaped         = esc_r;

`ifndef SYNTHESIS
  a_start_setup: assert property (@(posedge clk) disable iff (!rst_n)
    start && idle |=> state_r == S_SETUP_MUL)
    else $error("setup did not follow an accepted pixel");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_take |=> res_valid && $stable(result))
    else $error("pending result changed before it was taken");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ITER_EVAL |-> iter_r < MAX_K)
    else $error("round count ran past the limit");

  a_escaped_gray: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && result.escaped |->
      result.gray_level != 8'd0 && result.iteration_count < MAX_K)
    else $error("escaped pixel with bad gray or round count");

  a_bounded_black: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !result.escaped |->
      result.gray_level == 8'd0 && result.iteration_count == MAX_K)
    else $error("bounded pixel not black");
`endif

endmodule

### src/mandelbrot_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time evaluator for one pixel: maps column and row to c and counts
// z = z*z + c rounds until |z|^2 reaches 4 or the limit, giving a gray level.
// ----------------------------------------------------------------------------
// One pixel at a time: a new pixel is accepted only once the last result
//   has moved to the output register, which waits on out_ready. Each round
//   is a multiply state and an evaluate state on the shared multiplier.
// Reset: synchronous, active low; viewport registers return to their
//   defaults and the sequencer to idle, no clearing pass.
module mandelbrot_escape_time_pixel
  import mbet_pkg::*;
#(
  parameter int MAX_ITERATIONS = MBET_MAX_ITER,
  parameter int FRACTION_BITS  = MBET_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pix_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pix_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t       cfg;
  mul_ops_t   ops;
  mul_prods_t prods;
  logic       core_idle;
  logic       res_valid;
  logic       res_take;
  pix_out_t   result;
  logic       out_valid_r;
  pix_out_t   out_data_r;

  mbet_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbet_mul_unit u_mul (
    .clk   (clk),
    .ops   (ops),
    .prods (prods)
  );

  mbet_iter_core #(
    .MAX_ITERATIONS (MAX_ITERATIONS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .start     (in_valid && core_idle),
    .idle      (core_idle),
    .pix       (in_data),
    .ops       (ops),
    .prods     (prods),
    .res_valid (res_valid),
    .res_take  (res_take),
    .result    (result)
  );

  assign in_ready = core_idle;
  // Output slot is free when empty or draining this cycle
  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escape-time pixel evaluator. Pixels are sent
// through a valid/ready channel under several viewport settings; each result
// is compared field by field with a fixed-point escape-time predictor, except
// for a few directed probes whose result is known by inspection.
// ----------------------------------------------------------------------------
module tb;
  import mbet_pkg::*;

  localparam int          CLK_HALF     = 5;
  localparam int          RANDOM_ITEMS = 1000;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          DRAIN_CYCLES = 2 * MBET_MAX_ITER + 8;
  localparam logic [1:0]  REG_SPARE    = 2'd3;

  localparam pix_out_t ESC_AT_ONCE   = '{8'd255, 8'd0, 1'b1};
  localparam pix_out_t STAYS_BOUNDED = '{8'd0, 8'(MBET_MAX_ITER), 1'b0};
  localparam pix_out_t NOT_TYPED     = '0;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
    logic       known;
    pix_out_t   want;
  } probe_t;

  // Default viewport: column/row 250 sits at 88 LSB, 0 at -2.0 exactly
  localparam int N_PROBES = 16;
  probe_t probes [0:N_PROBES-1] = '{
    '{10'd0,    10'd0,    1'b1, ESC_AT_ONCE},
    '{10'd1023, 10'd1023, 1'b1, ESC_AT_ONCE},
    '{10'd250,  10'd250,  1'b1, STAYS_BOUNDED},
    '{10'd250,  10'd0,    1'b1, ESC_AT_ONCE},
    '{10'd0,    10'd250,  1'b1, ESC_AT_ONCE},
    '{10'd1023, 10'd0,    1'b0, NOT_TYPED},
    '{10'd0,    10'd1023, 1'b0, NOT_TYPED},
    '{10'd1,    10'd250,  1'b0, NOT_TYPED},
    '{10'd375,  10'd250,  1'b0, NOT_TYPED},
    '{10'd313,  10'd250,  1'b0, NOT_TYPED},
    '{10'd281,  10'd250,  1'b0, NOT_TYPED},
    '{10'd282,  10'd250,  1'b0, NOT_TYPED},
    '{10'd150,  10'd350,  1'b0, NOT_TYPED},
    '{10'd162,  10'd400,  1'b0, NOT_TYPED},
    '{10'd682,  10'd341,  1'b0, NOT_TYPED},
    '{10'd341,  10'd682,  1'b0, NOT_TYPED}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  pix_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  pix_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // Viewport as the block should hold it
  logic signed [31:0] view_real;
  logic signed [31:0] view_imag;
  logic        [27:0] view_step;

  pix_out_t expected_pixels [$];
  int       mismatches;
  int       cycles = 0;
  bit       no_idle;
  int       stall_left;

  mandelbrot_escape_time_pixel dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #CLK_HALF;
    clk = 1'b0;
    #CLK_HALF;
  end

  function automatic longint clamp_coord(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      return longint'(32'sh7FFF_FFFF);
    end else if (v < -longint'(64'sd2147483648)) begin
      return -longint'(64'sd2147483648);
    end
    return v;
  endfunction

  // Escape-time count in Q4.28 with floor-truncated products
  function automatic pix_out_t escape_gray(input pix_in_t p);
    longint   cr, ci, zr, zi, rr, ii, ri, four;
    int       k;
    bit       gone;
    pix_out_t res;
    cr   = clamp_coord(longint'(view_real) + longint'(p.pixel_column) * longint'(view_step));
    ci   = clamp_coord(longint'(view_imag) + longint'(p.pixel_row) * longint'(view_step));
    zr   = cr;
    zi   = ci;
    four = longint'(4) <<< MBET_FRAC_BITS;
    gone = 1'b0;
    for (k = 0; k < MBET_MAX_ITER; k++) begin
      rr = (zr * zr) >>> MBET_FRAC_BITS;
      ii = (zi * zi) >>> MBET_FRAC_BITS;
      if (rr + ii >= four) begin
        gone = 1'b1;
        break;
      end
      ri = (zr * zi) >>> (MBET_FRAC_BITS - 1);
      zr = clamp_coord(rr - ii + cr);
      zi = clamp_coord(ri + ci);
    end
    if (gone) begin
      res.gray_level      = 8'(255 - (255 * k + MBET_MAX_ITER - 1) / MBET_MAX_ITER);
      res.iteration_count = 8'(k);
      res.escaped         = 1'b1;
    end else begin
      res = STAYS_BOUNDED;
    end
    return res;
  endfunction

  task automatic send_pixel(input pix_in_t p, input bit known, input pix_out_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_pixels.insert(expected_pixels.size(), known ? want : escape_gray(p));
  endtask

  // Drop valid and wait for every pixel in flight to come back
  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ORIGIN_REAL: view_real = value;
      REG_ORIGIN_IMAG: view_imag = value;
      REG_PIXEL_STEP:  view_step = value[27:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side: hold ready low for a drawn number of cycles after each transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      stall_left <= no_idle ? 0 : $urandom_range(0, 13);
      out_ready  <= 1'b0;
    end else if (!out_ready) begin
      if (stall_left == 0) begin
        out_ready <= 1'b1;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    pix_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h", $time, out_data);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        report_field("gray_level", want.gray_level, out_data.gray_level);
        report_field("iteration_count", want.iteration_count, out_data.iteration_count);
        report_field("escaped", want.escaped, out_data.escaped);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int      sent;
    int      n;
    int      ph;
    int      i;
    pix_in_t p;
    logic [31:0] re, im, st;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_ORIGIN_REAL;
    cfg_data   <= '0;
    mismatches = 0;
    no_idle    = 1'b0;
    view_real  = ORIGIN_REAL_RST;
    view_imag  = ORIGIN_IMAG_RST;
    view_step  = PIXEL_STEP_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_PROBES; i++) begin
      no_idle = (i >= N_PROBES / 2);
      p.pixel_column = probes[i].col;
      p.pixel_row    = probes[i].row;
      send_pixel(p, probes[i].known, probes[i].want);
    end

    sent = 0;
    for (ph = 0; sent < RANDOM_ITEMS; ph++) begin
      case (ph)
        0: begin
          // far corner: real part saturates high, the step's top nibble is dropped
          re = 32'h7FFF_FFFF;
          im = 32'h8000_0000;
          st = 32'hFFFF_FFFF;
          n  = 20;
        end
        1: begin
          re = 32'h8000_0000;
          im = 32'h8000_0000;
          st = 32'h0000_0000;
          n  = 10;
        end
        2: begin
          re = 32'h0000_0000;
          im = 32'h0000_0000;
          st = 32'h0000_0000;
          n  = 10;
        end
        default: begin
          if ($urandom_range(0, 3) != 0) begin
            // keep the window over the interesting part of the plane
            re = $urandom_range(0, 805306368) - 671088640;
            im = $urandom_range(0, 536870912) - 402653184;
            st = {4'($urandom), 28'($urandom_range(1 << 12, 1 << 20))};
          end else begin
            re = $urandom;
            im = $urandom;
            st = $urandom;
          end
          n = $urandom_range(40, 120);
        end
      endcase
      drain_pixels();
      write_reg(REG_PIXEL_STEP, st);
      write_reg(REG_SPARE, $urandom);
      write_reg(REG_ORIGIN_REAL, re);
      write_reg(REG_ORIGIN_IMAG, im);
      no_idle = ($urandom_range(0, 3) == 0);
      for (i = 0; i < n; i++) begin
        p.pixel_column = $urandom_range(0, 1023);
        p.pixel_row    = $urandom_range(0, 1023);
        send_pixel(p, 1'b0, NOT_TYPED);
      end
      sent += n;
    end

    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
